/* rtl/tbk_pkg.sv */
// Shared types and constants for the multi-channel token bucket block.
// Holds operation and status codes and the request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package tbk_pkg;

   localparam int DEF_CHANNELS   = 8;
   localparam int DEF_COUNT_BITS = 16;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_TAKE   = 3'd1,
      OP_RETURN = 3'd2,
      OP_OPEN   = 3'd3,
      OP_CLOSE  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BLOCK  = 2'd1,
      ST_FULL   = 2'd2,
      ST_CLOSED = 2'd3
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  channel;
      logic [15:0] count;
      logic        use_rate;
      logic [15:0] rate_value;
      logic [15:0] burst_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic [15:0] granted;
      logic [15:0] tokens_now;
      status_type  status;
   } rsp_type;

endpackage

/* rtl/tbk_alloc.sv */
// Lowest-free-slot finder for the token bucket table.
// Depends on tbk_pkg for its default size.
`timescale 1ns / 1ps

module tbk_alloc #(
   parameter int CHANNELS = tbk_pkg::DEF_CHANNELS
) (
   input  logic [CHANNELS-1:0]  free_mask,
   output logic                 found,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] free_idx
);

   localparam int SLOT_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Scan from the top so the lowest free slot wins.
   always_comb begin
      found    = |free_mask;
      free_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            free_idx = SLOT_BITS'(i);
         end
      end
   end

endmodule

/* rtl/tbk_bucket_table.sv */
// Bucket state table and single-pass request logic.
// Depends on tbk_pkg and tbk_alloc.
`timescale 1ns / 1ps

module tbk_bucket_table #(
   parameter int CHANNELS   = tbk_pkg::DEF_CHANNELS,
   parameter int COUNT_BITS = tbk_pkg::DEF_COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  tbk_pkg::req_type req,
   output tbk_pkg::rsp_type rsp
);

   localparam int SLOT_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW        = COUNT_BITS;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] cap);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, cap}) ? cap : s[CW-1:0];
   endfunction

   logic [CW-1:0]       tokens_ff   [CHANNELS];
   logic [CW-1:0]       tokens_in   [CHANNELS];
   logic [CW-1:0]       rate_ff     [CHANNELS];
   logic [CW-1:0]       burst_ff    [CHANNELS];
   logic [CW-1:0]       tick_tokens [CHANNELS];
   logic [CHANNELS-1:0] in_use_ff;
   logic [CHANNELS-1:0] in_use_in;

   logic                 found;
   logic [SLOT_BITS-1:0] free_idx;
   logic [SLOT_BITS-1:0] ch_idx;
   logic                 ch_in_range;
   logic                 hit;
   logic                 wr_cfg;
   logic [CW-1:0]        cnt;
   logic [CW-1:0]        rate_in;
   logic [CW-1:0]        burst_in;
   logic [CW-1:0]        have;
   logic [CW-1:0]        want;
   logic [CW-1:0]        take_amt;
   logic [CW-1:0]        ret_sum;
   logic [CW-1:0]        grant;
   logic [CW-1:0]        now;

   tbk_alloc #(.CHANNELS(CHANNELS)) u_alloc (
      .free_mask (~in_use_ff),
      .found     (found),
      .free_idx  (free_idx)
   );

   assign cnt         = CW'(req.count);
   assign rate_in     = CW'(req.rate_value);
   assign burst_in    = CW'(req.burst_limit);
   assign ch_in_range = 32'(req.channel) < 32'(CHANNELS);
   assign ch_idx      = SLOT_BITS'(req.channel);
   assign hit         = ch_in_range && in_use_ff[ch_idx];
   assign have        = tokens_ff[ch_idx];
   assign want        = req.use_rate ? rate_ff[ch_idx] : cnt;
   assign take_amt    = (have < want) ? have : want;
   assign ret_sum     = sat_add(have, cnt, burst_ff[ch_idx]);

   // Refill every open slot in parallel.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         tick_tokens[i] = in_use_ff[i] ?
                          sat_add(tokens_ff[i], rate_ff[i], burst_ff[i]) : tokens_ff[i];
      end
   end

   always_comb begin
      tokens_in = tokens_ff;
      in_use_in = in_use_ff;
      wr_cfg    = 1'b0;
      grant     = '0;
      now       = '0;
      rsp.slot   = req.channel;
      rsp.status = tbk_pkg::ST_OK;
      unique case (req.op)
         tbk_pkg::OP_TICK: begin
            tokens_in = tick_tokens;
            now       = hit ? tick_tokens[ch_idx] : '0;
         end
         tbk_pkg::OP_TAKE: begin
            if (!hit) begin
               rsp.status = tbk_pkg::ST_CLOSED;
            end else if (have == '0) begin
               rsp.status = tbk_pkg::ST_BLOCK;
            end else begin
               grant             = take_amt;
               tokens_in[ch_idx] = have - take_amt;
               now               = have - take_amt;
            end
         end
         tbk_pkg::OP_RETURN: begin
            if (!hit) begin
               rsp.status = tbk_pkg::ST_CLOSED;
            end else begin
               tokens_in[ch_idx] = ret_sum;
               now               = ret_sum;
            end
         end
         tbk_pkg::OP_OPEN: begin
            if (!found) begin
               rsp.status = tbk_pkg::ST_FULL;
            end else begin
               in_use_in[free_idx] = 1'b1;
               tokens_in[free_idx] = '0;
               wr_cfg              = 1'b1;
               rsp.slot            = 3'(free_idx);
            end
         end
         tbk_pkg::OP_CLOSE: begin
            if (!hit) begin
               rsp.status = tbk_pkg::ST_CLOSED;
            end else begin
               in_use_in[ch_idx] = 1'b0;
               tokens_in[ch_idx] = '0;
            end
         end
         default: begin
            now = hit ? have : '0;
         end
      endcase
      rsp.granted    = 16'(grant);
      rsp.tokens_now = 16'(now);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tokens_ff <= '{default: '0};
         in_use_ff <= '0;
      end else if (fire) begin
         tokens_ff <= tokens_in;
         in_use_ff <= in_use_in;
      end
   end

   // Rate and burst are only read for open slots, so they need no reset.
   always_ff @(posedge clock) begin
      if (fire && wr_cfg) begin
         rate_ff[free_idx]  <= rate_in;
         burst_ff[free_idx] <= burst_in;
      end
   end

endmodule

/* rtl/multi_channel_token_bucket_top.sv */
// Top level of the multi-channel token bucket rate limiter.
// Depends on tbk_pkg and tbk_bucket_table (which uses tbk_alloc).
`timescale 1ns / 1ps

// A table of CHANNELS token buckets answering one transaction per clock for as
// long as the response side keeps up. Each request passes through an input
// register, one pass of combinational bucket logic, and a result register;
// the request moves from the input register into the result register when
// the result register is empty or being drained. That rate is set by the
// single pass between the two registers; a tick refills every open slot in
// that same pass since all buckets live in flip-flops. Open takes the lowest
// free slot and zeroes its tokens; a take on an empty bucket grants 0 with
// would-block status and the caller retries. There is no clearing pass after
// reset: the block accepts requests as soon as reset is released.
module multi_channel_token_bucket_top #(
   parameter int CHANNELS   = tbk_pkg::DEF_CHANNELS,
   parameter int COUNT_BITS = tbk_pkg::DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_channel,
   input  logic [15:0] req_count,
   input  logic        req_use_rate,
   input  logic [15:0] req_rate_value,
   input  logic [15:0] req_burst_limit,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_slot,
   output logic [15:0] rsp_granted,
   output logic [15:0] rsp_tokens_now,
   output logic [1:0]  rsp_status
);

   logic             in_valid_ff;
   logic             in_valid_in;
   tbk_pkg::req_type in_req_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   tbk_pkg::rsp_type rsp_ff;
   tbk_pkg::rsp_type rsp_calc;

   logic accept_in;
   logic advance;
   logic fire;

   // Move the held transaction on whenever the result register is empty or
   // being drained this cycle.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept_in = req_valid && !req_stall;

   assign in_valid_in  = accept_in || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload; hold it while stalled.
   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_req_ff.op          <= tbk_pkg::op_type'(req_op);
         in_req_ff.channel     <= req_channel;
         in_req_ff.count       <= req_count;
         in_req_ff.use_rate    <= req_use_rate;
         in_req_ff.rate_value  <= req_rate_value;
         in_req_ff.burst_limit <= req_burst_limit;
      end
   end

   // Bucket state and the single-pass request logic; state commits on fire.
   tbk_bucket_table #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_req_ff),
      .rsp   (rsp_calc)
   );

   // Load the result register with the response of the advancing transaction.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_ff.slot;
   assign rsp_granted    = rsp_ff.granted;
   assign rsp_tokens_now = rsp_ff.tokens_now;
   assign rsp_status     = rsp_ff.status;

   // A held request stays in the input register until the result side frees up.
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> (in_valid_ff && $stable(in_req_ff)))
      else $error("held request lost or changed while result register was stalled");

   // Only a successful transaction can grant tokens.
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != tbk_pkg::ST_OK)) |-> (rsp_granted == 16'd0))
      else $error("tokens granted on a failed transaction");

   // Would-block means the bucket really was empty.
   a_block_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == tbk_pkg::ST_BLOCK)) |-> (rsp_tokens_now == 16'd0))
      else $error("would-block reported with tokens left");

   // A closed slot or a full table reports no tokens.
   a_closed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == tbk_pkg::ST_CLOSED) || (rsp_status == tbk_pkg::ST_FULL)))
      |-> (rsp_tokens_now == 16'd0))
      else $error("tokens reported for a slot that is not open");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for multi_channel_token_bucket_top.
// Depends on tbk_pkg and the token bucket RTL; drives random and directed
// transactions and checks every response against an in-bench bucket table.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_SLOTS    = 8;
   localparam int RANDOM_ITEMS = 550;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 10;

   typedef struct {
      tbk_pkg::req_type req;
      bit               drain;   // hold this transaction until every response is back
   } pending_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [2:0]  req_channel = '0;
   logic [15:0] req_count = '0;
   logic        req_use_rate = 1'b0;
   logic [15:0] req_rate_value = '0;
   logic [15:0] req_burst_limit = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_slot;
   logic [15:0] rsp_granted;
   logic [15:0] rsp_tokens_now;
   logic [1:0]  rsp_status;

   multi_channel_token_bucket_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_channel    (req_channel),
      .req_count      (req_count),
      .req_use_rate   (req_use_rate),
      .req_rate_value (req_rate_value),
      .req_burst_limit(req_burst_limit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot       (rsp_slot),
      .rsp_granted    (rsp_granted),
      .rsp_tokens_now (rsp_tokens_now),
      .rsp_status     (rsp_status)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Bucket table mirror: updated once per accepted request.
   // ------------------------------------------------------------------
   logic [15:0] mirror_tokens [NUM_SLOTS];
   logic [15:0] mirror_rate   [NUM_SLOTS];
   logic [15:0] mirror_burst  [NUM_SLOTS];
   bit          mirror_in_use [NUM_SLOTS];

   pending_req_type  pending_reqs[$];
   tbk_pkg::rsp_type expected_rsps[$];
   int               error_count = 0;

   // Slots the stimulus generator believes are open; used to aim requests
   // at live buckets so most traffic gets past the not-open check.
   bit [NUM_SLOTS-1:0] gen_open = '0;

   function automatic logic [15:0] fill_bucket(input logic [15:0] level,
                                               input logic [15:0] amount,
                                               input logic [15:0] cap);
      logic [16:0] sum;
      sum = {1'b0, level} + {1'b0, amount};
      return (sum > {1'b0, cap}) ? cap : sum[15:0];
   endfunction

   function automatic tbk_pkg::rsp_type apply_bucket_op(input tbk_pkg::req_type r);
      tbk_pkg::rsp_type o;
      logic [15:0]      have;
      logic [15:0]      want;
      int               found;
      int               i;
      o.slot       = r.channel;
      o.granted    = '0;
      o.tokens_now = '0;
      o.status     = tbk_pkg::ST_OK;
      found        = -1;
      case (r.op)
         tbk_pkg::OP_TICK: begin
            // Refill every open bucket in the same step.
            for (i = 0; i < NUM_SLOTS; i++)
               if (mirror_in_use[i])
                  mirror_tokens[i] = fill_bucket(mirror_tokens[i], mirror_rate[i],
                                                 mirror_burst[i]);
            if (mirror_in_use[r.channel]) o.tokens_now = mirror_tokens[r.channel];
         end
         tbk_pkg::OP_TAKE, tbk_pkg::OP_RETURN, tbk_pkg::OP_CLOSE: begin
            if (!mirror_in_use[r.channel]) begin
               o.status = tbk_pkg::ST_CLOSED;
            end else if (r.op == tbk_pkg::OP_TAKE) begin
               have = mirror_tokens[r.channel];
               want = r.use_rate ? mirror_rate[r.channel] : r.count;
               if (have == '0) begin
                  o.status = tbk_pkg::ST_BLOCK;
               end else begin
                  o.granted = (have < want) ? have : want;
                  mirror_tokens[r.channel] = have - o.granted;
               end
               o.tokens_now = mirror_tokens[r.channel];
            end else if (r.op == tbk_pkg::OP_RETURN) begin
               mirror_tokens[r.channel] = fill_bucket(mirror_tokens[r.channel], r.count,
                                                      mirror_burst[r.channel]);
               o.tokens_now = mirror_tokens[r.channel];
            end else begin
               mirror_in_use[r.channel] = 1'b0;
               mirror_tokens[r.channel] = '0;
            end
         end
         tbk_pkg::OP_OPEN: begin
            for (i = NUM_SLOTS - 1; i >= 0; i--)
               if (!mirror_in_use[i]) found = i;
            if (found < 0) begin
               o.status = tbk_pkg::ST_FULL;
            end else begin
               mirror_in_use[found] = 1'b1;
               mirror_rate[found]   = r.rate_value;
               mirror_burst[found]  = r.burst_limit;
               mirror_tokens[found] = '0;
               o.slot               = found[2:0];
            end
         end
         default: begin
            if (mirror_in_use[r.channel]) o.tokens_now = mirror_tokens[r.channel];
         end
      endcase
      return o;
   endfunction

   // Mix of full-range, tiny and corner values so saturation and partial
   // grants show up often.
   function automatic logic [15:0] pick_value();
      logic [15:0] v;
      case ($urandom_range(0, 3))
         0: v = 16'($urandom);
         1: v = 16'($urandom_range(0, 8));
         2: begin
            case ($urandom_range(0, 3))
               0: v = 16'h0000;
               1: v = 16'hFFFF;
               2: v = 16'h8000;
               default: v = 16'h7FFF;
            endcase
         end
         default: v = 16'($urandom_range(0, 64));
      endcase
      return v;
   endfunction

   // Queue one transaction and track which slots it opens or frees.
   task automatic push_req(input tbk_pkg::op_type op, input logic [2:0] ch,
                           input logic [15:0] cnt, input bit by_rate,
                           input logic [15:0] rate, input logic [15:0] burst,
                           input bit drain);
      pending_req_type p;
      int              i;
      int              free_slot;
      free_slot           = -1;
      p.req.op            = op;
      p.req.channel       = ch;
      p.req.count         = cnt;
      p.req.use_rate      = by_rate;
      p.req.rate_value    = rate;
      p.req.burst_limit   = burst;
      p.drain             = drain;
      pending_reqs.push_back(p);
      if (op == tbk_pkg::OP_OPEN) begin
         for (i = NUM_SLOTS - 1; i >= 0; i--)
            if (!gen_open[i]) free_slot = i;
         if (free_slot >= 0) gen_open[free_slot] = 1'b1;
      end else if (op == tbk_pkg::OP_CLOSE) begin
         gen_open[ch] = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: present queued transactions, idling a random number of
   // cycles before each one, in alternating quiet and gappy stretches.
   // ------------------------------------------------------------------
   tbk_pkg::req_type cur_req;
   pending_req_type  next_req;
   int               gap_left = 0;
   int               sent_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            // Transaction accepted at this edge: advance the mirror.
            expected_rsps.push_back(apply_bucket_op(cur_req));
            sent_count++;
            gap_left = ((sent_count / 40) % 2 == 1) ? $urandom_range(0, 15) : 0;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
            next_req = pending_reqs.pop_front();
            cur_req  = next_req.req;
            req_valid       <= 1'b1;
            req_op          <= cur_req.op;
            req_channel     <= cur_req.channel;
            req_count       <= cur_req.count;
            req_use_rate    <= cur_req.use_rate;
            req_rate_value  <= cur_req.rate_value;
            req_burst_limit <= cur_req.burst_limit;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: stall each response a random number of cycles, then compare
   // the accepted response against the oldest expectation.
   // ------------------------------------------------------------------
   int               stall_left = 0;
   int               rsp_count = 0;
   tbk_pkg::rsp_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: slot %0d granted %0d tokens %0d",
                      rsp_slot, rsp_granted, rsp_tokens_now);
               error_count++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_slot !== want_rsp.slot) begin
                  $error("slot: expected %0d, actual %0d", want_rsp.slot, rsp_slot);
                  error_count++;
               end
               if (rsp_granted !== want_rsp.granted) begin
                  $error("granted: expected %0d, actual %0d", want_rsp.granted,
                         rsp_granted);
                  error_count++;
               end
               if (rsp_tokens_now !== want_rsp.tokens_now) begin
                  $error("tokens_now: expected %0d, actual %0d", want_rsp.tokens_now,
                         rsp_tokens_now);
                  error_count++;
               end
               if (rsp_status !== want_rsp.status) begin
                  $error("status: expected %0d, actual %0d", want_rsp.status,
                         rsp_status);
                  error_count++;
               end
            end
            rsp_count++;
            stall_left = ((rsp_count / 50) % 3 != 0) ? $urandom_range(0, 15) : 0;
         end
         // Hold off the next response for its drawn number of cycles.
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid) stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long.
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin
      int               n;
      int               pick;
      logic [2:0]       ch;
      tbk_pkg::op_type  op;

      for (n = 0; n < NUM_SLOTS; n++) begin
         mirror_tokens[n] = '0;
         mirror_rate[n]   = '0;
         mirror_burst[n]  = '0;
         mirror_in_use[n] = 1'b0;
      end

      // Directed part: requests on free slots, empty take, refill to the
      // ceiling, zero request, take by rate, saturating return, full table,
      // reuse of the lowest freed slot, tick that reports a closed channel.
      push_req(tbk_pkg::OP_TAKE,   3'd0, 16'd5,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_RETURN, 3'd7, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      push_req(tbk_pkg::OP_CLOSE,  3'd3, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TICK,   3'd0, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_OPEN,   3'd5, 16'd0,    1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
      push_req(tbk_pkg::OP_OPEN,   3'd0, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_OPEN,   3'd0, 16'd0,    1'b0, 16'd1,    16'd5,    1'b0);
      push_req(tbk_pkg::OP_TAKE,   3'd0, 16'd10,   1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TICK,   3'd2, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TAKE,   3'd0, 16'hFFFF, 1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TAKE,   3'd2, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TAKE,   3'd2, 16'd0,    1'b1, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_RETURN, 3'd0, 16'hFFFF, 1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_RETURN, 3'd2, 16'd100,  1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TAKE,   3'd1, 16'd1,    1'b1, 16'd0,    16'd0,    1'b0);
      for (n = 0; n < 5; n++)
         push_req(tbk_pkg::OP_OPEN, 3'(n), 16'd0, 1'b0, 16'(n + 2), 16'(10 * n + 3),
                  1'b0);
      push_req(tbk_pkg::OP_OPEN,   3'd6, 16'd0,    1'b0, 16'd9,    16'd9,    1'b0);
      push_req(tbk_pkg::OP_CLOSE,  3'd3, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_OPEN,   3'd0, 16'd0,    1'b0, 16'h7FFF, 16'h8000, 1'b0);
      push_req(tbk_pkg::OP_CLOSE,  3'd1, 16'd0,    1'b0, 16'd0,    16'd0,    1'b0);
      push_req(tbk_pkg::OP_TICK,   3'd1, 16'd0,    1'b0, 16'd0,    16'd0,    1'b1);

      // Random part: mostly requests aimed at open slots, some noise.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 18)      op = tbk_pkg::OP_TICK;
         else if (pick < 50) op = tbk_pkg::OP_TAKE;
         else if (pick < 65) op = tbk_pkg::OP_RETURN;
         else if (pick < 80) op = tbk_pkg::OP_OPEN;
         else if (pick < 92) op = tbk_pkg::OP_CLOSE;
         else begin
            case ($urandom_range(0, 4))
               0: op = tbk_pkg::OP_TICK;
               1: op = tbk_pkg::OP_TAKE;
               2: op = tbk_pkg::OP_RETURN;
               3: op = tbk_pkg::OP_OPEN;
               default: op = tbk_pkg::OP_CLOSE;
            endcase
         end
         ch = 3'($urandom_range(0, NUM_SLOTS - 1));
         if (pick < 92 && gen_open != '0 && $urandom_range(0, 9) < 8) begin
            while (!gen_open[ch]) ch = 3'($urandom_range(0, NUM_SLOTS - 1));
         end
         push_req(op, ch, pick_value(), 1'($urandom), pick_value(), pick_value(),
                  (n == 200 || n == 400));
      end

      while (reset) @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Hold reset at the start, then release it for the rest of the run.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

/* sim.f */
rtl/tbk_pkg.sv
rtl/tbk_alloc.sv
rtl/tbk_bucket_table.sv
rtl/multi_channel_token_bucket_top.sv
tb/sv/tb.sv
